### src/uvs_pkg.sv
// shared constants, reciprocal tables and types of the uv sphere vertex generator
`default_nettype none

package uvs_pkg;

    // largest segment count honored, larger settings are clamped to it
    localparam logic [7:0] MAX_SEGMENTS = 8'd255;

    // pi in unsigned q2.30 and one in q30
    localparam logic [31:0] PI_Q30  = 32'hC90F_DAA2;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam int unsigned HORNER_STAGES = 7;

    // divider shape shared by the angle and texture dividers
    localparam int unsigned DIV_NUM_W = 39;
    localparam int unsigned DIV_DEN_W = 9;
    localparam int unsigned DIV_BITS  = 4;
    localparam int unsigned DIV_LAT   = (DIV_NUM_W + DIV_BITS - 1) / DIV_BITS;

    // x squared, product and one minus registers of each horner stage, final sine multiply
    localparam int unsigned TRIG_LAT = 2 * HORNER_STAGES + 2;

    // delay from item accept to result strobe
    localparam int unsigned LATENCY = 3 + DIV_LAT + TRIG_LAT + 2;

    // exact floor division of a 32 bit value by a small constant:
    // q = (n * ceil(2^s / d)) >> s with s = 32 + ceil(log2 d)
    localparam int unsigned SIN_SHR [HORNER_STAGES] = '{40, 40, 39, 39, 38, 37, 35};
    localparam int unsigned COS_SHR [HORNER_STAGES] = '{40, 40, 39, 38, 37, 36, 33};

    localparam logic [32:0] SIN_RCP [HORNER_STAGES] = '{
        33'(((64'd1 << 40) + 64'd209) / 64'd210),
        33'(((64'd1 << 40) + 64'd155) / 64'd156),
        33'(((64'd1 << 39) + 64'd109) / 64'd110),
        33'(((64'd1 << 39) + 64'd71)  / 64'd72),
        33'(((64'd1 << 38) + 64'd41)  / 64'd42),
        33'(((64'd1 << 37) + 64'd19)  / 64'd20),
        33'(((64'd1 << 35) + 64'd5)   / 64'd6)
    };

    localparam logic [32:0] COS_RCP [HORNER_STAGES] = '{
        33'(((64'd1 << 40) + 64'd181) / 64'd182),
        33'(((64'd1 << 40) + 64'd131) / 64'd132),
        33'(((64'd1 << 39) + 64'd89)  / 64'd90),
        33'(((64'd1 << 38) + 64'd55)  / 64'd56),
        33'(((64'd1 << 37) + 64'd29)  / 64'd30),
        33'(((64'd1 << 36) + 64'd11)  / 64'd12),
        33'(((64'd1 << 33) + 64'd1)   / 64'd2)
    };

    // per item side information that rides alongside the arithmetic
    typedef struct packed {
        logic            vld;
        logic            lat_cn;
        logic            lat_half;
        logic            lon_sn;
        logic            lon_cn;
        logic            lon_half;
        logic            quad_valid;
        logic [5:0][15:0] corner;
    } side_t;

endpackage

`default_nettype wire

### src/uvs_div.sv
// pipelined restoring divider, a few quotient bits per stage
`default_nettype none

module uvs_div #(
    parameter int unsigned NUM_W = 39,
    parameter int unsigned DEN_W = 9,
    parameter int unsigned BITS  = 4
) (
    input  wire logic             clk,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [NUM_W-1:0] quo
);

    localparam int unsigned NSTG  = (NUM_W + BITS - 1) / BITS;
    localparam int unsigned PAD_W = NSTG * BITS;

    logic [PAD_W-1:0] num_reg [NSTG];
    logic [PAD_W-1:0] quo_reg [NSTG];
    logic [DEN_W-1:0] rem_reg [NSTG];
    logic [DEN_W-1:0] den_reg [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        logic [PAD_W-1:0] n_in;
        logic [PAD_W-1:0] q_in;
        logic [DEN_W-1:0] r_in;
        logic [DEN_W-1:0] d_in;
        logic [PAD_W-1:0] n_next;
        logic [PAD_W-1:0] q_next;
        logic [DEN_W-1:0] r_next;

        if (s == 0) begin : g_first
            assign n_in = PAD_W'(num);
            assign q_in = '0;
            assign r_in = '0;
            assign d_in = den;
        end else begin : g_rest
            assign n_in = num_reg[s-1];
            assign q_in = quo_reg[s-1];
            assign r_in = rem_reg[s-1];
            assign d_in = den_reg[s-1];
        end

        always_comb
        begin
            logic [DEN_W:0] r;
            r      = {1'b0, r_in};
            n_next = n_in;
            q_next = q_in;
            for (int b = 0; b < BITS; b++)
            begin
                r      = {r[DEN_W-1:0], n_next[PAD_W-1]};
                n_next = n_next << 1;
                q_next = q_next << 1;
                if (r >= {1'b0, d_in})
                begin
                    r         = r - {1'b0, d_in};
                    q_next[0] = 1'b1;
                end
            end
            r_next = r[DEN_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            num_reg[s] <= n_next;
            quo_reg[s] <= q_next;
            rem_reg[s] <= r_next;
            den_reg[s] <= d_in;
        end
    end

    assign quo = quo_reg[NSTG-1][NUM_W-1:0];

endmodule

`default_nettype wire

### src/uvs_trig.sv
// pipelined sine and cosine magnitudes by horner form taylor series in q30
`default_nettype none

module uvs_trig (
    input  wire logic        clk,
    input  wire logic [31:0] x,
    output logic      [31:0] sin_mag,
    output logic      [31:0] cos_mag
);

    localparam int unsigned NS = uvs_pkg::HORNER_STAGES;

    logic [31:0] x_reg  [2*NS+1];
    logic [31:0] x2_reg [2*NS-1];
    logic [31:0] sp_reg [NS];
    logic [31:0] cp_reg [NS];
    logic [30:0] sa_reg [NS];
    logic [30:0] ca_reg [NS];
    logic [31:0] sin_reg;
    logic [31:0] cos_reg;
    logic [63:0] x2_full;
    logic [62:0] sin_full;

    assign x2_full = 64'(x) * 64'(x);

    always_ff @(posedge clk)
    begin
        x_reg[0]  <= x;
        x2_reg[0] <= x2_full[61:30];
        for (int k = 1; k < 2 * NS + 1; k++)
        begin
            x_reg[k] <= x_reg[k-1];
        end
        for (int k = 1; k < 2 * NS - 1; k++)
        begin
            x2_reg[k] <= x2_reg[k-1];
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_horner
        logic [30:0] s_prev;
        logic [30:0] c_prev;
        logic [62:0] s_prod;
        logic [62:0] c_prod;
        logic [64:0] s_quo;
        logic [64:0] c_quo;
        logic [31:0] s_q;
        logic [31:0] c_q;

        if (g == 0) begin : g_first
            assign s_prev = uvs_pkg::ONE_Q30;
            assign c_prev = uvs_pkg::ONE_Q30;
        end else begin : g_rest
            assign s_prev = sa_reg[g-1];
            assign c_prev = ca_reg[g-1];
        end

        // product stage
        assign s_prod = 63'(x2_reg[2*g]) * 63'(s_prev);
        assign c_prod = 63'(x2_reg[2*g]) * 63'(c_prev);

        // constant divide and one minus
        assign s_quo = 65'(sp_reg[g]) * 65'(uvs_pkg::SIN_RCP[g]);
        assign c_quo = 65'(cp_reg[g]) * 65'(uvs_pkg::COS_RCP[g]);
        assign s_q   = 32'(s_quo >> uvs_pkg::SIN_SHR[g]);
        assign c_q   = 32'(c_quo >> uvs_pkg::COS_SHR[g]);

        always_ff @(posedge clk)
        begin
            sp_reg[g] <= s_prod[61:30];
            cp_reg[g] <= c_prod[61:30];
            sa_reg[g] <= (s_q >= 32'(uvs_pkg::ONE_Q30)) ? '0
                                                        : 31'(32'(uvs_pkg::ONE_Q30) - s_q);
            ca_reg[g] <= (c_q >= 32'(uvs_pkg::ONE_Q30)) ? '0
                                                        : 31'(32'(uvs_pkg::ONE_Q30) - c_q);
        end
    end

    assign sin_full = 63'(x_reg[2*NS]) * 63'(sa_reg[NS-1]);

    always_ff @(posedge clk)
    begin
        sin_reg <= sin_full[61:30];
        cos_reg <= 32'(ca_reg[NS-1]);
    end

    assign sin_mag = sin_reg;
    assign cos_mag = cos_reg;

endmodule

`default_nettype wire

### src/uvs_delay.sv
// fixed depth delay line for side information and texture coordinates
`default_nettype none

module uvs_delay #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [WIDTH-1:0] d,
    output logic      [WIDTH-1:0] q
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                pipe_reg[k] <= '0;
            end
        end
        else
        begin
            pipe_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                pipe_reg[k] <= pipe_reg[k-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];

endmodule

`default_nettype wire

### src/uv_sphere_vertex_generator_core.sv
// uv sphere vertex generator: position, texture and quad indices of one grid point
// done and the result pass the clamp, fold, numerator, divider, trig, product and output stages
// throughput: one item per cycle; busy never rises, the pipeline has no stall path
// the result is shown for exactly one cycle with done; the receiver cannot hold it off
// reset: asynchronous active low, clears all valid bits and sets segments to 16
`default_nettype none

module uv_sphere_vertex_generator_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item input
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  row,
    input  wire logic [7:0]  col,
    // segment count register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    // results
    output logic             done,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] pos_z,
    output logic [15:0]      tex_u,
    output logic [15:0]      tex_v,
    output logic [15:0]      corner0,
    output logic [15:0]      corner1,
    output logic [15:0]      corner2,
    output logic [15:0]      corner3,
    output logic [15:0]      corner4,
    output logic [15:0]      corner5,
    output logic             quad_valid
);

    localparam int unsigned SIDE_W = $bits(uvs_pkg::side_t);
    localparam int unsigned NUM_W  = uvs_pkg::DIV_NUM_W;
    localparam int unsigned DEN_W  = uvs_pkg::DIV_DEN_W;

    function automatic logic [15:0] apply_sign(input logic [17:0] mag, input logic neg);
        logic [15:0] m16;
        m16 = mag[15:0];
        return (neg && (mag != '0)) ? 16'(~m16 + 16'd1) : m16;
    endfunction

    // ------------------------------------------------------------------
    // segment count register; each item carries the count it entered with
    // ------------------------------------------------------------------
    logic [7:0] segments_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segments_reg <= 8'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            segments_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // ------------------------------------------------------------------
    // stage 1: clamp segment count, row and column
    // ------------------------------------------------------------------
    logic       f1_vld_reg;
    logic [7:0] f1_p_reg;
    logic [7:0] f1_i_reg;
    logic [7:0] f1_j_reg;
    logic [7:0] p_clamp;

    always_comb
    begin
        if (segments_reg == 8'd0)
        begin
            p_clamp = 8'd1;
        end
        else if (segments_reg > uvs_pkg::MAX_SEGMENTS)
        begin
            p_clamp = uvs_pkg::MAX_SEGMENTS;
        end
        else
        begin
            p_clamp = segments_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
        end
        else
        begin
            f1_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_p_reg <= p_clamp;
        f1_i_reg <= (row > p_clamp) ? p_clamp : row;
        f1_j_reg <= (col > p_clamp) ? p_clamp : col;
    end

    // ------------------------------------------------------------------
    // stage 2: fold both angles into [0, pi/2] with sign flags
    // latitude angle is pi*i/p, longitude angle is pi*2j/p
    // ------------------------------------------------------------------
    logic       f2_vld_reg;
    logic [7:0] f2_p_reg;
    logic [7:0] f2_i_reg;
    logic [7:0] f2_j_reg;
    logic [6:0] f2_lat_t_reg;
    logic       f2_lat_cn_reg;
    logic       f2_lat_half_reg;
    logic [6:0] f2_lon_t_reg;
    logic       f2_lon_sn_reg;
    logic       f2_lon_cn_reg;
    logic       f2_lon_half_reg;

    logic [9:0] p10;
    logic [9:0] lat_t;
    logic       lat_cn;
    logic [9:0] lon_t;
    logic       lon_sn;
    logic       lon_cn;

    always_comb
    begin
        p10 = 10'(f1_p_reg);

        lat_t  = 10'(f1_i_reg);
        lat_cn = 1'b0;
        if (lat_t >= p10)
        begin
            lat_t  = lat_t - p10;
            lat_cn = 1'b1;
        end
        if ({lat_t[8:0], 1'b0} > p10)
        begin
            lat_t  = p10 - lat_t;
            lat_cn = !lat_cn;
        end

        // 2j reaches 2p only at the clamp, a full turn
        lon_t  = {1'b0, f1_j_reg, 1'b0};
        lon_sn = 1'b0;
        lon_cn = 1'b0;
        if (lon_t == {p10[8:0], 1'b0})
        begin
            lon_t = '0;
        end
        if (lon_t >= p10)
        begin
            lon_t  = lon_t - p10;
            lon_sn = 1'b1;
            lon_cn = 1'b1;
        end
        if ({lon_t[8:0], 1'b0} > p10)
        begin
            lon_t  = p10 - lon_t;
            lon_cn = !lon_cn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f2_vld_reg <= 1'b0;
        end
        else
        begin
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f2_p_reg        <= f1_p_reg;
        f2_i_reg        <= f1_i_reg;
        f2_j_reg        <= f1_j_reg;
        f2_lat_t_reg    <= lat_t[6:0];
        f2_lat_cn_reg   <= lat_cn;
        f2_lat_half_reg <= ({lat_t[8:0], 1'b0} == p10);
        f2_lon_t_reg    <= lon_t[6:0];
        f2_lon_sn_reg   <= lon_sn;
        f2_lon_cn_reg   <= lon_cn;
        f2_lon_half_reg <= ({lon_t[8:0], 1'b0} == p10);
    end

    // ------------------------------------------------------------------
    // stage 3: divider numerators and the base vertex index
    // ------------------------------------------------------------------
    logic             f3_vld_reg;
    logic [7:0]       f3_p_reg;
    logic [8:0]       f3_w_reg;
    logic [16:0]      f3_k_reg;
    logic             f3_quad_reg;
    logic             f3_lat_cn_reg;
    logic             f3_lat_half_reg;
    logic             f3_lon_sn_reg;
    logic             f3_lon_cn_reg;
    logic             f3_lon_half_reg;
    logic [NUM_W-1:0] f3_lat_num_reg;
    logic [NUM_W-1:0] f3_lon_num_reg;
    logic [23:0]      f3_u_num_reg;
    logic [23:0]      f3_v_num_reg;
    logic [8:0]       w_next;

    assign w_next = 9'(f2_p_reg) + 9'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f3_vld_reg <= 1'b0;
        end
        else
        begin
            f3_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f3_p_reg        <= f2_p_reg;
        f3_w_reg        <= w_next;
        f3_k_reg        <= 17'(17'(f2_i_reg) * 17'(w_next)) + 17'(f2_j_reg);
        f3_quad_reg     <= (f2_i_reg < f2_p_reg) && (f2_j_reg < f2_p_reg);
        f3_lat_cn_reg   <= f2_lat_cn_reg;
        f3_lat_half_reg <= f2_lat_half_reg;
        f3_lon_sn_reg   <= f2_lon_sn_reg;
        f3_lon_cn_reg   <= f2_lon_cn_reg;
        f3_lon_half_reg <= f2_lon_half_reg;
        // reduced angle in q2.30, rounded: (pi * t + p/2) / p
        f3_lat_num_reg  <= NUM_W'(NUM_W'(uvs_pkg::PI_Q30) * NUM_W'(f2_lat_t_reg))
                           + NUM_W'(f2_p_reg >> 1);
        f3_lon_num_reg  <= NUM_W'(NUM_W'(uvs_pkg::PI_Q30) * NUM_W'(f2_lon_t_reg))
                           + NUM_W'(f2_p_reg >> 1);
        // texture n/p rounded half up: (n * 65536 + p) / (2p)
        f3_u_num_reg    <= {f2_j_reg, 8'd0, f2_p_reg};
        f3_v_num_reg    <= {f2_i_reg, 8'd0, f2_p_reg};
    end

    // ------------------------------------------------------------------
    // quad corners and side information, delayed to meet the trig results
    // ------------------------------------------------------------------
    uvs_pkg::side_t side_in;
    uvs_pkg::side_t side_out;
    logic [15:0]    k16;
    logic [15:0]    w16;

    assign k16 = f3_k_reg[15:0];
    assign w16 = 16'(f3_w_reg);

    always_comb
    begin
        side_in.vld        = f3_vld_reg;
        side_in.lat_cn     = f3_lat_cn_reg;
        side_in.lat_half   = f3_lat_half_reg;
        side_in.lon_sn     = f3_lon_sn_reg;
        side_in.lon_cn     = f3_lon_cn_reg;
        side_in.lon_half   = f3_lon_half_reg;
        side_in.quad_valid = f3_quad_reg;
        if (f3_quad_reg)
        begin
            side_in.corner[0] = k16;
            side_in.corner[1] = k16 + 16'd1;
            side_in.corner[2] = k16 + w16;
            side_in.corner[3] = k16 + 16'd1;
            side_in.corner[4] = k16 + w16 + 16'd1;
            side_in.corner[5] = k16 + w16;
        end
        else
        begin
            side_in.corner = '0;
        end
    end

    uvs_delay #(
        .WIDTH (SIDE_W),
        .DEPTH (uvs_pkg::DIV_LAT + uvs_pkg::TRIG_LAT)
    ) u_side_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .d     (side_in),
        .q     (side_out)
    );

    // ------------------------------------------------------------------
    // dividers: two reduced angles and two texture coordinates
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] lat_x_quo;
    logic [NUM_W-1:0] lon_x_quo;
    logic [NUM_W-1:0] u_quo;
    logic [NUM_W-1:0] v_quo;
    logic [DEN_W-1:0] den_p;
    logic [DEN_W-1:0] den_2p;

    assign den_p  = DEN_W'(f3_p_reg);
    assign den_2p = DEN_W'({f3_p_reg, 1'b0});

    uvs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .BITS(uvs_pkg::DIV_BITS)) u_div_lat (
        .clk (clk),
        .num (f3_lat_num_reg),
        .den (den_p),
        .quo (lat_x_quo)
    );

    uvs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .BITS(uvs_pkg::DIV_BITS)) u_div_lon (
        .clk (clk),
        .num (f3_lon_num_reg),
        .den (den_p),
        .quo (lon_x_quo)
    );

    uvs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .BITS(uvs_pkg::DIV_BITS)) u_div_u (
        .clk (clk),
        .num (NUM_W'(f3_u_num_reg)),
        .den (den_2p),
        .quo (u_quo)
    );

    uvs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .BITS(uvs_pkg::DIV_BITS)) u_div_v (
        .clk (clk),
        .num (NUM_W'(f3_v_num_reg)),
        .den (den_2p),
        .quo (v_quo)
    );

    // ------------------------------------------------------------------
    // sine and cosine of both reduced angles
    // ------------------------------------------------------------------
    logic [31:0] lat_sin;
    logic [31:0] lat_cos;
    logic [31:0] lon_sin;
    logic [31:0] lon_cos;
    logic [31:0] tex_dly;

    uvs_trig u_trig_lat (
        .clk     (clk),
        .x       (lat_x_quo[31:0]),
        .sin_mag (lat_sin),
        .cos_mag (lat_cos)
    );

    uvs_trig u_trig_lon (
        .clk     (clk),
        .x       (lon_x_quo[31:0]),
        .sin_mag (lon_sin),
        .cos_mag (lon_cos)
    );

    uvs_delay #(
        .WIDTH (32),
        .DEPTH (uvs_pkg::TRIG_LAT)
    ) u_tex_dly (
        .clk   (clk),
        .rst_n (rst_n),
        .d     ({u_quo[15:0], v_quo[15:0]}),
        .q     (tex_dly)
    );

    // ------------------------------------------------------------------
    // product stage: exact quarter turn override, then x and z products
    // ------------------------------------------------------------------
    logic [31:0] sl_eff;
    logic [31:0] cl_eff;
    logic [31:0] so_eff;
    logic [31:0] co_eff;

    logic           m_vld_reg;
    logic [63:0]    m_prod_x_reg;
    logic [63:0]    m_prod_z_reg;
    logic [31:0]    m_cl_reg;
    logic [31:0]    m_tex_reg;
    uvs_pkg::side_t m_side_reg;

    assign sl_eff = side_out.lat_half ? 32'(uvs_pkg::ONE_Q30) : lat_sin;
    assign cl_eff = side_out.lat_half ? 32'd0 : lat_cos;
    assign so_eff = side_out.lon_half ? 32'(uvs_pkg::ONE_Q30) : lon_sin;
    assign co_eff = side_out.lon_half ? 32'd0 : lon_cos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= side_out.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        m_prod_x_reg <= 64'(co_eff) * 64'(sl_eff);
        m_prod_z_reg <= 64'(so_eff) * 64'(sl_eff);
        m_cl_reg     <= cl_eff;
        m_tex_reg    <= tex_dly;
        m_side_reg   <= side_out;
    end

    // ------------------------------------------------------------------
    // output stage: round to q14, apply signs
    // ------------------------------------------------------------------
    logic [63:0] x_round;
    logic [63:0] z_round;
    logic [32:0] y_round;

    assign x_round = m_prod_x_reg + (64'd1 << 45);
    assign z_round = m_prod_z_reg + (64'd1 << 45);
    assign y_round = 33'(m_cl_reg) + 33'h8000;

    logic        done_reg;
    logic [15:0] pos_x_reg;
    logic [15:0] pos_y_reg;
    logic [15:0] pos_z_reg;
    logic [15:0] tex_u_reg;
    logic [15:0] tex_v_reg;
    logic [5:0][15:0] corner_reg;
    logic        quad_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg      <= apply_sign(x_round[63:46], !m_side_reg.lon_cn);
        pos_y_reg      <= apply_sign({1'b0, y_round[32:16]}, !m_side_reg.lat_cn);
        pos_z_reg      <= apply_sign(z_round[63:46], m_side_reg.lon_sn);
        tex_u_reg      <= m_tex_reg[31:16];
        tex_v_reg      <= m_tex_reg[15:0];
        corner_reg     <= m_side_reg.corner;
        quad_valid_reg <= m_side_reg.quad_valid;
    end

    assign done       = done_reg;
    assign pos_x      = pos_x_reg;
    assign pos_y      = pos_y_reg;
    assign pos_z      = pos_z_reg;
    assign tex_u      = tex_u_reg;
    assign tex_v      = tex_v_reg;
    assign corner0    = corner_reg[0];
    assign corner1    = corner_reg[1];
    assign corner2    = corner_reg[2];
    assign corner3    = corner_reg[3];
    assign corner4    = corner_reg[4];
    assign corner5    = corner_reg[5];
    assign quad_valid = quad_valid_reg;

endmodule

`default_nettype wire

### src/uvs_check.sv
// port level checks of the uv sphere vertex generator, bound to the top level
`default_nettype none

module uvs_check (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [7:0]         row,
    input wire logic [7:0]         col,
    input wire logic               done,
    input wire logic signed [15:0] pos_y,
    input wire logic signed [15:0] pos_z,
    input wire logic [15:0]        tex_v
);

    localparam int unsigned LAT = uvs_pkg::LATENCY;

    // every strobe traces back to an accepted item
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without an accepted item");

    // every accepted item yields a result after the fixed latency
    a_item_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item produced no result");

    // the south pole row maps to y of minus one and v of zero
    a_pole_row: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(row, LAT) == 8'd0)) |-> (pos_y == -16'sd16384) && (tex_v == 16'd0))
        else $error("row zero result wrong");

    // column zero lies in the z equal zero plane
    a_seam_col: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ($past(col, LAT) == 8'd0)) |-> (pos_z == 16'sd0))
        else $error("column zero result wrong");

endmodule

bind uv_sphere_vertex_generator_core uvs_check u_uvs_check (.*);

`default_nettype wire

### tb/tb_uv_sphere_vertex_generator_core.sv
// testbench of the uv sphere vertex generator: directed table, then random grid points
`default_nettype none

module tb_uv_sphere_vertex_generator_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 950;
    localparam longint unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DIR_ROWS = 21;

    // one expected result of the block
    typedef struct {
        logic [15:0] x, y, z, u, v;
        logic [15:0] c [6];
        logic        qv;
    } vertex_t;

    // one row of the directed table; known = 1 means the vertex is typed in
    typedef struct {
        logic [7:0] seg;
        logic [7:0] r, c;
        bit         known;
        logic [15:0] x, y, z, u, v;
        logic        qv;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  row;
    logic [7:0]  col;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        done;
    logic signed [15:0] pos_x, pos_y, pos_z;
    logic [15:0] tex_u, tex_v;
    logic [15:0] corner0, corner1, corner2, corner3, corner4, corner5;
    logic        quad_valid;

    uv_sphere_vertex_generator_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .row        (row),
        .col        (col),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .done       (done),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .tex_u      (tex_u),
        .tex_v      (tex_v),
        .corner0    (corner0),
        .corner1    (corner1),
        .corner2    (corner2),
        .corner3    (corner3),
        .corner4    (corner4),
        .corner5    (corner5),
        .quad_valid (quad_valid)
    );

    // segment count as the predictor sees it, follows every accepted write
    logic [7:0] seg_shadow;
    vertex_t    vertex_queue [$];
    int         fail_count;
    longint unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // one horner stage: 1 - trunc(trunc(x2*acc >> 30) / div), floored at zero
    function automatic logic [63:0] horner_step(logic [63:0] x2, logic [63:0] acc,
                                                logic [63:0] div);
        logic [63:0] t;
        t = ((x2 * acc) >> 30) / div;
        return (t >= 64'h4000_0000) ? 64'd0 : 64'h4000_0000 - t;
    endfunction

    // sine and cosine magnitudes in q30 plus signs of angle k*pi/d
    task automatic angle_trig(input logic [63:0] k, input logic [63:0] d,
                              output logic [63:0] s_mag, output bit s_neg,
                              output logic [63:0] c_mag, output bit c_neg);
        logic [63:0] t, x, x2, a;
        t = k % (2 * d);
        s_neg = 0;
        c_neg = 0;
        if (t >= d)
        begin
            t = t - d;
            s_neg = 1;
            c_neg = 1;
        end
        if (2 * t > d)
        begin
            t = d - t;
            c_neg = !c_neg;
        end
        if (2 * t == d)
        begin
            // exact right angle
            s_mag = 64'h4000_0000;
            c_mag = 0;
        end
        else
        begin
            x  = (64'(uvs_pkg::PI_Q30) * t + d / 2) / d;
            x2 = (x * x) >> 30;
            a = horner_step(x2, 64'h4000_0000, 210);
            a = horner_step(x2, a, 156);
            a = horner_step(x2, a, 110);
            a = horner_step(x2, a, 72);
            a = horner_step(x2, a, 42);
            a = horner_step(x2, a, 20);
            a = horner_step(x2, a, 6);
            s_mag = (x * a) >> 30;
            a = horner_step(x2, 64'h4000_0000, 182);
            a = horner_step(x2, a, 132);
            a = horner_step(x2, a, 90);
            a = horner_step(x2, a, 56);
            a = horner_step(x2, a, 30);
            a = horner_step(x2, a, 12);
            a = horner_step(x2, a, 2);
            c_mag = a;
        end
    endtask

    // sign applied after rounding, so zero stays +0
    function automatic logic [15:0] apply_sign(logic [63:0] mag, bit neg);
        if (neg && mag != 0)
            return 16'(17'h10000 - 17'(mag[15:0]));
        return mag[15:0];
    endfunction

    function automatic logic [15:0] tex_coord(logic [63:0] n, logic [63:0] p);
        return 16'((n * 65536 + p) / (2 * p));
    endfunction

    task automatic predict_vertex(input logic [7:0] seg, input logic [7:0] r_in,
                                  input logic [7:0] c_in, output vertex_t vx);
        logic [63:0] p, i, j, sl, cl, so, co, w, k;
        bit sln, cln, son, con;
        p = (seg == 0) ? 1 : 64'(seg);
        if (p > 64'(uvs_pkg::MAX_SEGMENTS))
            p = 64'(uvs_pkg::MAX_SEGMENTS);
        i = (r_in > p) ? p : 64'(r_in);
        j = (c_in > p) ? p : 64'(c_in);
        angle_trig(i, p, sl, sln, cl, cln);
        angle_trig(2 * j, p, so, son, co, con);
        vx.x = apply_sign((co * sl + (64'd1 << 45)) >> 46, !con);
        vx.y = apply_sign((cl + (64'd1 << 15)) >> 16, !cln);
        vx.z = apply_sign((so * sl + (64'd1 << 45)) >> 46, son);
        vx.u = tex_coord(j, p);
        vx.v = tex_coord(i, p);
        if (i < p && j < p)
        begin
            w = p + 1;
            k = i * w + j;
            vx.c[0] = 16'(k);
            vx.c[1] = 16'(k + 1);
            vx.c[2] = 16'(k + w);
            vx.c[3] = 16'(k + 1);
            vx.c[4] = 16'(k + w + 1);
            vx.c[5] = 16'(k + w);
            vx.qv = 1'b1;
        end
        else
        begin
            foreach (vx.c[n])
                vx.c[n] = 16'd0;
            vx.qv = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // result checking at the rising edge, done is a one cycle strobe
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n && done === 1'b1)
        begin
            if (vertex_queue.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual %h %h %h",
                         $time, pos_x, pos_y, pos_z);
                fail_count++;
            end
            else
            begin
                want = vertex_queue.pop_front();
                check_field("pos_x", want.x, pos_x);
                check_field("pos_y", want.y, pos_y);
                check_field("pos_z", want.z, pos_z);
                check_field("tex_u", want.u, tex_u);
                check_field("tex_v", want.v, tex_v);
                check_field("corner0", want.c[0], corner0);
                check_field("corner1", want.c[1], corner1);
                check_field("corner2", want.c[2], corner2);
                check_field("corner3", want.c[3], corner3);
                check_field("corner4", want.c[4], corner4);
                check_field("corner5", want.c[5], corner5);
                check_field("quad_valid", 16'(want.qv), 16'(quad_valid));
            end
        end
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // sender burst state: items left in this burst
    int burst_left;

    // drive one item at the falling edge, hold until accepted at a rising edge;
    // keeps start high across back to back items, with random bursts and gaps
    task automatic send_item(input logic [7:0] r_in, input logic [7:0] c_in,
                             input vertex_t vx);
        int gap;
        if (burst_left == 0)
        begin
            // end of burst: unless the random gap is zero, lower start and idle for it
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        start <= 1'b1;
        row   <= r_in;
        col   <= c_in;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        vertex_queue = {vertex_queue, vx};
        burst_left--;
        @(negedge clk);
    endtask

    // wait until every expected result has come, then a little longer
    task automatic drain;
        start <= 1'b0;
        while (vertex_queue.size() != 0)
            @(negedge clk);
        repeat (uvs_pkg::LATENCY + 4) @(negedge clk);
    endtask

    // register write, only while the pipeline is empty
    task automatic write_segments(input logic [7:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        seg_shadow = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= 8'($urandom());
    endtask

    // random grid point, mostly inside the sphere, sometimes clamped
    task automatic random_point(output logic [7:0] r_o, output logic [7:0] c_o);
        int unsigned p;
        p = (seg_shadow == 0) ? 1 : seg_shadow;
        if ($urandom_range(0, 9) == 0)
        begin
            r_o = 8'($urandom());
            c_o = 8'($urandom());
        end
        else
        begin
            r_o = 8'($urandom_range(0, p));
            c_o = 8'($urandom_range(0, p));
        end
    endtask

    // directed rows; unknown rows go through the predictor
    dir_row_t dir_table [DIR_ROWS] = '{
        // reset setting, poles and equator corners
        '{8'd16, 8'd0,   8'd0,   1, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 1'b1},
        '{8'd16, 8'd16,  8'd16,  1, 16'h0000, 16'h4000, 16'h0000, 16'h8000, 16'h8000, 1'b0},
        '{8'd16, 8'd8,   8'd0,   1, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 1'b1},
        '{8'd16, 8'd8,   8'd4,   1, 16'h0000, 16'h0000, 16'h4000, 16'h2000, 16'h4000, 1'b1},
        '{8'd16, 8'd8,   8'd8,   1, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h4000, 1'b1},
        '{8'd16, 8'd255, 8'd255, 1, 16'h0000, 16'h4000, 16'h0000, 16'h8000, 16'h8000, 1'b0},
        '{8'd16, 8'd15,  8'd15,  0, 0, 0, 0, 0, 0, 0},
        '{8'd16, 8'd3,   8'd11,  0, 0, 0, 0, 0, 0, 0},
        // zero segments taken as one
        '{8'd0,  8'd0,   8'd0,   1, 16'h0000, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 1'b1},
        '{8'd0,  8'd1,   8'd1,   1, 16'h0000, 16'h4000, 16'h0000, 16'h8000, 16'h8000, 1'b0},
        '{8'd0,  8'd200, 8'd0,   0, 0, 0, 0, 0, 0, 0},
        // one segment
        '{8'd1,  8'd0,   8'd1,   0, 0, 0, 0, 0, 0, 0},
        '{8'd1,  8'd1,   8'd0,   0, 0, 0, 0, 0, 0, 0},
        // largest setting, corner indices near the top of the range
        '{8'd255, 8'd254, 8'd254, 0, 0, 0, 0, 0, 0, 0},
        '{8'd255, 8'd255, 8'd0,   0, 0, 0, 0, 0, 0, 0},
        '{8'd255, 8'd0,   8'd255, 0, 0, 0, 0, 0, 0, 0},
        '{8'd255, 8'd170, 8'd85,  0, 0, 0, 0, 0, 0, 0},
        '{8'd255, 8'd127, 8'd64,  0, 0, 0, 0, 0, 0, 0},
        // odd count, no exact right angle
        '{8'd7,  8'd3,   8'd2,   0, 0, 0, 0, 0, 0, 0},
        '{8'd7,  8'd4,   8'd6,   0, 0, 0, 0, 0, 0, 0},
        '{8'd7,  8'd9,   8'd5,   0, 0, 0, 0, 0, 0, 0}
    };

    initial
    begin
        vertex_t vx;
        logic [7:0] r_v, c_v;
        int n;
        logic [7:0] seg_choice;

        rst_n      = 1'b0;
        start      = 1'b0;
        row        = 8'd0;
        col        = 8'd0;
        cfg_valid  = 1'b0;
        cfg_data   = 8'd0;
        fail_count = 0;
        cycle_count = 0;
        burst_left = 0;
        seg_shadow = 8'd16;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table, reset setting first, writes where the setting changes
        foreach (dir_table[t])
        begin
            if (dir_table[t].seg != seg_shadow)
                write_segments(dir_table[t].seg);
            predict_vertex(seg_shadow, dir_table[t].r, dir_table[t].c, vx);
            if (dir_table[t].known)
            begin
                // hand typed values replace the predicted position, texture and quad flag
                vx.x = dir_table[t].x;
                vx.y = dir_table[t].y;
                vx.z = dir_table[t].z;
                vx.u = dir_table[t].u;
                vx.v = dir_table[t].v;
                vx.qv = dir_table[t].qv;
                if (!vx.qv)
                    foreach (vx.c[m])
                        vx.c[m] = 16'd0;
            end
            send_item(dir_table[t].r, dir_table[t].c, vx);
        end

        // full pause: let every expected result come before going on
        drain();

        // random phases over several settings, extremes among them
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            if (n % 95 == 0)
            begin
                case ($urandom_range(0, 5))
                    0: seg_choice = 8'd1;
                    1: seg_choice = 8'd255;
                    2: seg_choice = 8'd0;
                    default: seg_choice = 8'($urandom_range(2, 64));
                endcase
                write_segments(seg_choice);
            end
            random_point(r_v, c_v);
            predict_vertex(seg_shadow, r_v, c_v, vx);
            send_item(r_v, c_v, vx);
            n++;
        end

        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
src/uvs_pkg.sv
src/uvs_div.sv
src/uvs_trig.sv
src/uvs_delay.sv
src/uv_sphere_vertex_generator_core.sv
src/uvs_check.sv
tb/tb_uv_sphere_vertex_generator_core.sv
